FILE: hw/rtl/aca_pkg.sv
// Shared constants, request and status codes, and controller states for the automaton.
package aca_pkg;

  localparam int NODE_W      = 10;
  localparam int LET_W       = 5;
  localparam int MAX_NODES   = 1024;
  localparam int ALPHABET    = 26;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CA_W        = $clog2(CHILD_DEPTH);
  localparam int CNT_W       = $clog2(MAX_NODES) + 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_MOVE   = 2'd1;
  localparam logic [1:0] REQ_LINK   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_INS,
    S_END,
    S_LOOK,
    S_LOOK2,
    S_FQ,
    S_FU,
    S_FF,
    S_FR,
    S_FW,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/aca_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module aca_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/aho_corasick_automaton.sv
// Aho-Corasick automaton: builds a trie one letter per insert beat and answers
// transition and suffix link queries. One beat is handled at a time. After reset
// a clearing pass (one child table entry a cycle) holds in_stall high. Inserts
// and memoized queries step through decode, lookup, end mark and result states,
// paced by the registered read data of the child, memo and end mark memories.
// The first query after the trie has grown first refills the memo tables with a
// breadth-first sweep that reads, then writes, each child slot of every queued
// node on the child and transition memories. A finished result waits in the
// output register while the next beat is taken.
module aho_corasick_automaton import aca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [LET_W-1:0]  letter,
  input  logic              last_letter,
  input  logic [NODE_W-1:0] state_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] node,
  output logic              is_end,
  output logic [1:0]        status
);

  state_t state, state_next;
  logic [CA_W-1:0]   clr_cnt, clr_cnt_next;
  logic [1:0]        req_r, req_r_next;
  logic [LET_W-1:0]  letter_r, letter_r_next;
  logic              last_r, last_r_next;
  logic [NODE_W-1:0] sidx_r, sidx_r_next;
  logic [NODE_W-1:0] cursor, cursor_next;
  logic [CNT_W-1:0]  node_count, node_count_next;
  logic              memo_valid, memo_valid_next;
  logic [CA_W-1:0]   addr_r, addr_r_next;
  logic [NODE_W-1:0] res_node, res_node_next;
  logic              res_end, res_end_next;
  status_t           res_status, res_status_next;
  logic              out_valid_next;
  logic [NODE_W-1:0] node_next;
  logic              is_end_next;
  logic [1:0]        status_next;
  logic [CNT_W-1:0]  head, head_next, tail, tail_next;
  logic [NODE_W-1:0] u_r, u_r_next;
  logic [CA_W-1:0]   ubase, ubase_next, fbase, fbase_next;
  logic [LET_W-1:0]  c_r, c_r_next;

  logic              ch_we, mv_we, fl_we, em_we, q_we;
  logic [CA_W-1:0]   ch_waddr, ch_raddr, mv_waddr, mv_raddr;
  logic [NODE_W-1:0] ch_wdata, ch_rdata, mv_wdata, mv_rdata;
  logic [NODE_W-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic [NODE_W-1:0] em_waddr, em_raddr;
  logic              em_wdata, em_rdata;
  logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  logic [CA_W-1:0]   ins_addr, qry_addr;
  logic [NODE_W-1:0] via;
  logic              bad_letter;

  aca_ram #(.DEPTH(CHILD_DEPTH), .WIDTH(NODE_W)) u_child (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata), .raddr(ch_raddr), .rdata(ch_rdata)
  );
  aca_ram #(.DEPTH(CHILD_DEPTH), .WIDTH(NODE_W)) u_move (
    .clk, .we(mv_we), .waddr(mv_waddr), .wdata(mv_wdata), .raddr(mv_raddr), .rdata(mv_rdata)
  );
  aca_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
    .clk, .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata), .raddr(fl_raddr), .rdata(fl_rdata)
  );
  aca_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_end (
    .clk, .we(em_we), .waddr(em_waddr), .wdata(em_wdata), .raddr(em_raddr), .rdata(em_rdata)
  );
  aca_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  assign ins_addr   = CA_W'(cursor) * CA_W'(ALPHABET) + CA_W'(letter_r);
  assign qry_addr   = CA_W'(sidx_r) * CA_W'(ALPHABET) + CA_W'(letter_r);
  assign bad_letter = letter_r >= LET_W'(ALPHABET);
  assign via        = (u_r == '0) ? '0 : mv_rdata;
  assign in_stall   = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      cursor     <= '0;
      node_count <= CNT_W'(1);
      memo_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      cursor     <= cursor_next;
      node_count <= node_count_next;
      memo_valid <= memo_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_r_next;
    letter_r   <= letter_r_next;
    last_r     <= last_r_next;
    sidx_r     <= sidx_r_next;
    addr_r     <= addr_r_next;
    res_node   <= res_node_next;
    res_end    <= res_end_next;
    res_status <= res_status_next;
    node       <= node_next;
    is_end     <= is_end_next;
    status     <= status_next;
    head       <= head_next;
    tail       <= tail_next;
    u_r        <= u_r_next;
    ubase      <= ubase_next;
    fbase      <= fbase_next;
    c_r        <= c_r_next;
  end

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    req_r_next      = req_r;
    letter_r_next   = letter_r;
    last_r_next     = last_r;
    sidx_r_next     = sidx_r;
    cursor_next     = cursor;
    node_count_next = node_count;
    memo_valid_next = memo_valid;
    addr_r_next     = addr_r;
    res_node_next   = res_node;
    res_end_next    = res_end;
    res_status_next = res_status;
    out_valid_next  = out_valid && out_stall;
    node_next       = node;
    is_end_next     = is_end;
    status_next     = status;
    head_next       = head;
    tail_next       = tail;
    u_r_next        = u_r;
    ubase_next      = ubase;
    fbase_next      = fbase;
    c_r_next        = c_r;

    ch_we = 1'b0; ch_waddr = addr_r; ch_wdata = '0; ch_raddr = addr_r;
    mv_we = 1'b0; mv_waddr = ubase + CA_W'(c_r); mv_wdata = via; mv_raddr = addr_r;
    fl_we = 1'b0; fl_waddr = ch_rdata; fl_wdata = via; fl_raddr = sidx_r;
    em_we = 1'b0; em_waddr = cursor; em_wdata = 1'b0; em_raddr = cursor;
    q_we  = 1'b0; q_waddr = tail[NODE_W-1:0]; q_wdata = ch_rdata; q_raddr = head[NODE_W-1:0];

    case (state)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_cnt;
        em_we    = clr_cnt < CA_W'(MAX_NODES);
        em_waddr = clr_cnt[NODE_W-1:0];
        clr_cnt_next = clr_cnt + CA_W'(1);
        if (clr_cnt == CA_W'(CHILD_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_r_next    = req_type;
          letter_r_next = letter;
          last_r_next   = last_letter;
          sidx_r_next   = state_index;
          state_next    = S_DEC;
        end
      end
      S_DEC: begin
        ch_raddr = ins_addr;
        em_raddr = cursor;
        addr_r_next = (req_r == REQ_INSERT) ? ins_addr : qry_addr;
        res_node_next   = '0;
        res_end_next    = 1'b0;
        res_status_next = ST_OK;
        if (req_r == REQ_INSERT) begin
          if (bad_letter) begin
            res_node_next   = cursor;
            res_status_next = ST_BAD;
            state_next      = S_END;
          end else begin
            state_next = S_INS;
          end
        end else if (req_r == REQ_MOVE || req_r == REQ_LINK) begin
          if (CNT_W'(sidx_r) >= node_count || (req_r == REQ_MOVE && bad_letter)) begin
            res_status_next = ST_BAD;
            state_next      = S_DONE;
          end else if (!memo_valid) begin
            // seed the breadth-first refill with the root
            head_next  = '0;
            tail_next  = CNT_W'(1);
            q_we       = 1'b1;
            q_waddr    = '0;
            q_wdata    = '0;
            fl_we      = 1'b1;
            fl_waddr   = '0;
            fl_wdata   = '0;
            state_next = S_FQ;
          end else begin
            state_next = S_LOOK;
          end
        end else begin
          res_status_next = ST_BAD;
          state_next      = S_DONE;
        end
      end
      S_INS: begin
        if (ch_rdata == '0) begin
          if (node_count >= CNT_W'(MAX_NODES)) begin
            // abandon the rest of this pattern
            res_node_next   = cursor;
            res_status_next = ST_FULL;
            em_raddr        = cursor;
            cursor_next     = '0;
            state_next      = S_END;
          end else begin
            ch_we    = 1'b1;
            ch_wdata = node_count[NODE_W-1:0];
            em_we    = 1'b1;
            em_waddr = node_count[NODE_W-1:0];
            em_wdata = last_r;
            node_count_next = node_count + CNT_W'(1);
            memo_valid_next = 1'b0;
            res_node_next   = node_count[NODE_W-1:0];
            res_end_next    = last_r;
            cursor_next     = last_r ? '0 : node_count[NODE_W-1:0];
            state_next      = S_DONE;
          end
        end else begin
          res_node_next = ch_rdata;
          cursor_next   = last_r ? '0 : ch_rdata;
          if (last_r) begin
            em_we        = 1'b1;
            em_waddr     = ch_rdata;
            em_wdata     = 1'b1;
            res_end_next = 1'b1;
            state_next   = S_DONE;
          end else begin
            em_raddr   = ch_rdata;
            state_next = S_END;
          end
        end
      end
      S_END: begin
        res_end_next = em_rdata;
        state_next   = S_DONE;
      end
      S_LOOK: begin
        mv_raddr   = addr_r;
        fl_raddr   = sidx_r;
        state_next = S_LOOK2;
      end
      S_LOOK2: begin
        res_node_next = (req_r == REQ_MOVE) ? mv_rdata : fl_rdata;
        em_raddr      = res_node_next;
        state_next    = S_END;
      end
      S_FQ: begin
        q_raddr = head[NODE_W-1:0];
        if (head == tail) begin
          memo_valid_next = 1'b1;
          state_next      = S_LOOK;
        end else begin
          state_next = S_FU;
        end
      end
      S_FU: begin
        u_r_next   = q_rdata;
        fl_raddr   = q_rdata;
        ubase_next = CA_W'(q_rdata) * CA_W'(ALPHABET);
        head_next  = head + CNT_W'(1);
        state_next = S_FF;
      end
      S_FF: begin
        fbase_next = CA_W'(fl_rdata) * CA_W'(ALPHABET);
        c_r_next   = '0;
        state_next = S_FR;
      end
      S_FR: begin
        ch_raddr   = ubase + CA_W'(c_r);
        mv_raddr   = fbase + CA_W'(c_r);
        state_next = S_FW;
      end
      S_FW: begin
        mv_we    = 1'b1;
        mv_waddr = ubase + CA_W'(c_r);
        if (ch_rdata != '0 && CNT_W'(ch_rdata) < node_count) begin
          mv_wdata  = ch_rdata;
          fl_we     = 1'b1;
          fl_waddr  = ch_rdata;
          fl_wdata  = via;
          q_we      = 1'b1;
          tail_next = tail + CNT_W'(1);
        end else begin
          mv_wdata = via;
        end
        c_r_next = c_r + LET_W'(1);
        if (c_r == LET_W'(ALPHABET - 1)) begin
          state_next = S_FQ;
        end else begin
          state_next = S_FR;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          node_next      = res_node;
          is_end_next    = res_end;
          status_next    = res_status;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/aca_checker.sv
// Port-level checks for the automaton, bound to the top level.
module aca_checker import aca_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        req_type,
  input logic [LET_W-1:0]  letter,
  input logic              last_letter,
  input logic [NODE_W-1:0] state_index,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] node,
  input logic              is_end,
  input logic [1:0]        status
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node) && $stable(is_end) && $stable(status))
    else $error("stalled result beat changed");

  // the root never ends a pattern
  a_root_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && node == '0 |-> !is_end)
    else $error("root reported as pattern end");

  // an accepted link query holds the input while it is worked on
  a_bad_len: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_LINK |=> in_stall)
    else $error("query accepted without work cycles");

  // clearing pass blocks input and no result is pending after reset
  a_reset: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind aho_corasick_automaton aca_checker u_aca_checker (.*);

FILE: verif/aho_corasick_automaton_tb.sv
// Self-checking testbench for the Aho-Corasick automaton: trie inserts, transition and link queries.
module aho_corasick_automaton_tb;
  import aca_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              is_end;
    logic [1:0]        status;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = REQ_INSERT;
  logic [LET_W-1:0]  letter = '0;
  logic              last_letter = 1'b0;
  logic [NODE_W-1:0] state_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] node;
  logic              is_end;
  logic [1:0]        status;

  aho_corasick_automaton uut (.*);

  initial forever #10 clk = ~clk;

  // trie mirror
  int unsigned trie_child [CHILD_DEPTH];
  int unsigned goto_memo [CHILD_DEPTH];
  int unsigned link_memo [MAX_NODES];
  bit          end_flag [MAX_NODES];
  int unsigned sweep_q [MAX_NODES];
  int unsigned nodes_used;
  int unsigned cursor;
  bit          links_fresh;

  answer_t answers_due[$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, full_seen = 0, bad_seen = 0;
  int burst_left = 0;
  int hold_ask = 0, hold_seen = 0, hold_cnt = 0;
  bit stall_on = 1'b0;
  int idle_cycles = 0;

  function automatic void rebuild_links();
    int unsigned head, tail, u, f, w, via;
    head = 0;
    tail = 0;
    sweep_q[tail++] = 0;
    link_memo[0] = 0;
    while (head < tail) begin
      u = sweep_q[head++];
      f = link_memo[u];
      for (int c = 0; c < ALPHABET; c++) begin
        w = trie_child[u * ALPHABET + c];
        via = (u == 0) ? 0 : goto_memo[f * ALPHABET + c];
        if (w != 0 && w < nodes_used && tail < MAX_NODES) begin
          link_memo[w] = via;
          goto_memo[u * ALPHABET + c] = w;
          sweep_q[tail++] = w;
        end else begin
          goto_memo[u * ALPHABET + c] = via;
        end
      end
    end
    links_fresh = 1'b1;
  endfunction

  function automatic answer_t predict_answer(logic [1:0] rq, logic [LET_W-1:0] lt, logic la,
                                             logic [NODE_W-1:0] si);
    answer_t r;
    int unsigned w, n;
    r = '0;
    r.status = ST_OK;
    if (rq == REQ_INSERT) begin
      if (lt >= ALPHABET) begin
        r.node = NODE_W'(cursor);
        r.is_end = end_flag[cursor];
        r.status = ST_BAD;
      end else begin
        w = trie_child[cursor * ALPHABET + lt];
        if (w == 0 && nodes_used >= MAX_NODES) begin
          r.node = NODE_W'(cursor);
          r.is_end = end_flag[cursor];
          r.status = ST_FULL;
          cursor = 0;
          return r;
        end
        if (w == 0) begin
          w = nodes_used++;
          trie_child[cursor * ALPHABET + lt] = w;
          end_flag[w] = 1'b0;
          links_fresh = 1'b0;
        end
        if (la) begin
          end_flag[w] = 1'b1;
          cursor = 0;
        end else begin
          cursor = w;
        end
        r.node = NODE_W'(w);
        r.is_end = end_flag[w];
      end
    end else if (rq == REQ_MOVE || rq == REQ_LINK) begin
      if (si >= nodes_used || (rq == REQ_MOVE && lt >= ALPHABET)) begin
        r.status = ST_BAD;
      end else begin
        if (!links_fresh) rebuild_links();
        n = (rq == REQ_MOVE) ? goto_memo[si * ALPHABET + lt] : link_memo[si];
        if (n >= MAX_NODES) n = 0;
        r.node = NODE_W'(n);
        r.is_end = end_flag[n];
      end
    end else begin
      r.status = ST_BAD;
    end
    return r;
  endfunction

  // Drive one beat, wait for acceptance, then maybe open a gap.
  task automatic send_beat(int rq, int lt, int la, int si);
    bit stalled;
    in_valid <= 1'b1;
    req_type <= 2'(rq);
    letter <= LET_W'(lt);
    last_letter <= 1'(la);
    state_index <= NODE_W'(si);
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    answers_due.insert(answers_due.size(),
                       predict_answer(2'(rq), LET_W'(lt), 1'(la), NODE_W'(si)));
    beats_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic insert_word(int len, int top);
    for (int i = 0; i < len; i++)
      send_beat(REQ_INSERT, $urandom_range(0, top), i == len - 1, 0);
  endtask

  task automatic test_directed();
    // he, she, his, hers over letters e=4 h=7 i=8 r=17 s=18
    int unsigned words [4][4] = '{'{7, 4, 99, 0}, '{18, 7, 4, 99}, '{7, 8, 18, 99},
                                  '{7, 4, 17, 18}};
    for (int p = 0; p < 4; p++)
      for (int i = 0; i < 4 && words[p][i] != 99; i++)
        send_beat(REQ_INSERT, words[p][i], i == 3 || words[p][i + 1] == 99, 0);
    send_beat(REQ_INSERT, 25, 1, 0);
    send_beat(REQ_INSERT, 7, 0, 0);
    send_beat(REQ_INSERT, 31, 0, 1023);   // bad letter mid pattern
    send_beat(REQ_INSERT, 26, 1, 0);
    send_beat(REQ_INSERT, 4, 1, 0);
    send_beat(REQ_MOVE, 7, 0, 5);
    send_beat(REQ_MOVE, 0, 0, 0);
    send_beat(REQ_MOVE, 25, 0, 3);
    send_beat(REQ_MOVE, 30, 0, 2);  // bad letter query
    send_beat(REQ_LINK, 31, 1, 5);
    send_beat(REQ_LINK, 0, 0, 3);
    send_beat(REQ_LINK, 0, 0, 0);
    send_beat(REQ_LINK, 0, 0, 1023); // bad index
    send_beat(REQ_MOVE, 1, 0, nodes_used);
    send_beat(REQ_NONE, 21, 1, 'h2AA);
    send_beat(REQ_MOVE, 17, 0, 7);
  endtask

  task automatic test_random(int total);
    int stop;
    stop = beats_in + total;
    while (beats_in < stop) begin
      stall_on = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) insert_word($urandom_range(1, 4), 2);
      repeat ($urandom_range(4, 12)) begin
        case ($urandom_range(0, 9))
          0: send_beat(REQ_INSERT, $urandom_range(0, 31), $urandom_range(0, 1), $urandom);
          1: send_beat($urandom_range(1, 3), $urandom_range(0, 31), $urandom_range(0, 1),
                       $urandom);
          2: send_beat(REQ_MOVE, $urandom_range(0, 25), 0,
                       $urandom_range(0, nodes_used - 1));
          3, 4, 5: send_beat(REQ_MOVE, $urandom_range(0, 2), $urandom_range(0, 1),
                             $urandom_range(0, nodes_used - 1));
          default: send_beat(REQ_LINK, $urandom_range(0, 31), $urandom_range(0, 1),
                             $urandom_range(0, nodes_used - 1));
        endcase
      end
    end
  endtask

  task automatic test_pressure();
    hold_ask++;
    repeat (20) send_beat(REQ_LINK, 0, 0, $urandom_range(0, nodes_used - 1));
    drain();
    repeat (10) send_beat(REQ_MOVE, $urandom_range(0, 2), 0,
                          $urandom_range(0, nodes_used - 1));
  endtask

  task automatic test_table_full();
    while (nodes_used < MAX_NODES) insert_word($urandom_range(6, 12), 25);
    repeat (12) insert_word($urandom_range(1, 4), 25);
    send_beat(REQ_LINK, 0, 0, 1023);
    send_beat(REQ_MOVE, 25, 0, 1023);
    repeat (30) send_beat($urandom_range(1, 2), $urandom_range(0, 25), 0, $urandom);
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
  end

  // check results and watch for a hang
  always @(negedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (status == ST_FULL) full_seen++;
        if (status == ST_BAD) bad_seen++;
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: node %0d is_end %0d status %0d",
                   $time, node, is_end, status);
        end else begin
          want = answers_due.pop_front();
          if (node !== want.node) begin
            errors++;
            $display("%0t: node expected %0d actual %0d", $time, want.node, node);
          end
          if (is_end !== want.is_end) begin
            errors++;
            $display("%0t: is_end expected %0d actual %0d", $time, want.is_end, is_end);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results pending", $time, answers_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    nodes_used = 1;
    cursor = 0;
    links_fresh = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(150);
    test_pressure();
    test_table_full();
    drain();
    repeat (100) @(posedge clk);
    if (answers_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, answers_due.size());
    end
    $display("Sent %0d beats, checked %0d results (%0d table full, %0d bad request).",
             beats_in, beats_out, full_seen, bad_seen);
    $display("Trie grew to %0d nodes; errors: %0d.", nodes_used, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/aca_pkg.sv
hw/rtl/aca_ram.sv
hw/rtl/aho_corasick_automaton.sv
hw/rtl/aca_checker.sv
verif/aho_corasick_automaton_tb.sv
